[hw/rtl/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, sequencer step codes and defaults for the first-fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int BLOCK_BYTES_DEF  = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int FREE_ENTRIES_DEF = 64;
  localparam int USED_ENTRIES_DEF = 64;

  localparam logic [31:0] HEAP_START_RST = 32'd0;
  localparam logic [31:0] HEAP_END_RST   = 32'd1048576;

  // command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OOM      = 2'd1;
  localparam logic [1:0] STAT_NOTALLOC = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // register indexes
  localparam logic [7:0] REG_HEAP_START = 8'd0;
  localparam logic [7:0] REG_HEAP_END   = 8'd1;

  // sequencer steps
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_START   = 5'd1;
  localparam logic [4:0] S_A_RD    = 5'd2;
  localparam logic [4:0] S_A_CMP   = 5'd3;
  localparam logic [4:0] S_U_SCAN  = 5'd4;
  localparam logic [4:0] S_A_UPD   = 5'd5;
  localparam logic [4:0] S_DN_RD   = 5'd6;
  localparam logic [4:0] S_DN_WR   = 5'd7;
  localparam logic [4:0] S_F_RD    = 5'd8;
  localparam logic [4:0] S_F_CMP   = 5'd9;
  localparam logic [4:0] S_P_RD    = 5'd10;
  localparam logic [4:0] S_P_CMP   = 5'd11;
  localparam logic [4:0] S_F_DEC   = 5'd12;
  localparam logic [4:0] S_UP_RD   = 5'd13;
  localparam logic [4:0] S_UP_WR   = 5'd14;
  localparam logic [4:0] S_L_START = 5'd15;
  localparam logic [4:0] S_L_RD    = 5'd16;
  localparam logic [4:0] S_L_CMP   = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  typedef struct packed {
    logic [4:0] op;
    logic       load;
  } ffa_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       bad_need;
    logic       free_end;
    logic       fit;
    logic       used_end;
    logic       uvalid;
    logic       hit;
    logic       at_pos;
    logic       split;
    logic       full;
    logic       mprev;
    logic       mnext;
    logic       dn_last;
    logic       up_last;
  } ffa_stat_t;

endpackage

[hw/rtl/ffa_ram.sv]
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// Alloc/free/init sequencer; drives the datapath a step a cycle unless held.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ffa_pkg::ffa_stat_t stat,
  output ffa_pkg::ffa_cmd_t  cmd
);
  import ffa_pkg::*;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.op    = state;
  assign cmd.load  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_START;
      S_START: begin
        case (stat.cmd)
          CMD_ALLOC: state_next = stat.bad_need ? S_L_START : S_A_RD;
          CMD_FREE:  state_next = S_F_RD;
          default:   state_next = S_L_START;
        endcase
      end
      S_A_RD:    state_next = stat.free_end ? S_L_START : S_A_CMP;
      S_A_CMP:   state_next = stat.fit ? S_U_SCAN : S_A_RD;
      S_U_SCAN: begin
        if (stat.used_end) state_next = S_L_START;
        else if (!stat.uvalid) state_next = S_A_UPD;
      end
      S_A_UPD:   state_next = stat.split ? S_L_START : S_DN_RD;
      S_DN_RD:   state_next = stat.dn_last ? S_L_START : S_DN_WR;
      S_DN_WR:   state_next = S_DN_RD;
      S_F_RD:    state_next = stat.used_end ? S_L_START : S_F_CMP;
      S_F_CMP:   state_next = stat.hit ? S_P_RD : S_F_RD;
      S_P_RD:    state_next = stat.free_end ? S_F_DEC : S_P_CMP;
      S_P_CMP:   state_next = stat.at_pos ? S_F_DEC : S_P_RD;
      S_F_DEC: begin
        if (stat.full) state_next = S_L_START;
        else if (stat.mprev && stat.mnext) state_next = S_DN_RD;
        else if (!stat.mprev && !stat.mnext) state_next = S_UP_RD;
        else state_next = S_L_START;
      end
      S_UP_RD:   state_next = stat.up_last ? S_L_START : S_UP_WR;
      S_UP_WR:   state_next = S_UP_RD;
      S_L_START: state_next = S_L_RD;
      S_L_RD:    state_next = stat.free_end ? S_OUT : S_L_CMP;
      S_L_CMP:   state_next = S_L_RD;
      S_OUT:     if (out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/ffa_dp.sv]
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath: free and used segment tables, scan counters, merge arithmetic.
// ----------------------------------------------------------------------------
module ffa_dp #(
  parameter int BLOCK_BYTES  = 64,
  parameter int HEADER_BYTES = 16,
  parameter int FREE_ENTRIES = 64,
  parameter int USED_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_req_size,
  input  logic [31:0]        in_address,
  input  ffa_pkg::ffa_cmd_t  cmd,
  output ffa_pkg::ffa_stat_t stat,
  output logic [1:0]         status,
  output logic [31:0]        result_address,
  output logic [31:0]        free_bytes,
  output logic [31:0]        largest_free_bytes
);
  import ffa_pkg::*;

  localparam int FAW = $clog2(FREE_ENTRIES);
  localparam int FIW = $clog2(FREE_ENTRIES + 1);
  localparam int UAW = $clog2(USED_ENTRIES);
  localparam int UIW = $clog2(USED_ENTRIES + 1);
  localparam logic [33:0]    BLK34  = 34'(BLOCK_BYTES);
  localparam logic [33:0]    HDR34  = 34'(HEADER_BYTES);
  localparam logic [31:0]    HDR32  = 32'(HEADER_BYTES);
  localparam logic [FIW-1:0] FREE_N = FIW'(FREE_ENTRIES);
  localparam logic [UIW-1:0] USED_N = UIW'(USED_ENTRIES);

  logic [31:0]           heap_start;
  logic [31:0]           heap_end;
  logic [1:0]            op_cmd;
  logic [31:0]           addr;
  logic [33:0]           need;
  logic [FIW-1:0]        count;
  logic [31:0]           fbc;
  logic [FIW-1:0]        fidx;
  logic [UIW-1:0]        uidx;
  logic [FAW-1:0]        fi;
  logic [31:0]           base;
  logic [31:0]           seglen;
  logic [31:0]           s;
  logic [31:0]           l;
  logic [UAW-1:0]        j;
  logic [FIW-1:0]        pos;
  logic                  nex;
  logic [31:0]           pstart;
  logic [31:0]           plen;
  logic [31:0]           nstart;
  logic [31:0]           nlen;
  logic [31:0]           best;
  logic [1:0]            st_r;
  logic [31:0]           res_r;
  logic [USED_ENTRIES-1:0] valid;

  logic [63:0]    f_rdata;
  logic [63:0]    u_rdata;
  logic [31:0]    f_rstart;
  logic [31:0]    f_rlen;
  logic [31:0]    u_rstart;
  logic           f_we;
  logic [FAW-1:0] f_waddr;
  logic [63:0]    f_wdata;
  logic [FAW-1:0] f_raddr;
  logic           u_we;
  logic [FIW-1:0] f_inc;
  logic [FIW-1:0] f_dec;
  logic [FIW-1:0] pos_m1;
  logic [31:0]    rem;
  logic           heap_ok;

  assign f_rstart = f_rdata[31:0];
  assign f_rlen   = f_rdata[63:32];
  assign u_rstart = u_rdata[31:0];
  assign f_inc    = fidx + FIW'(1);
  assign f_dec    = fidx - FIW'(1);
  assign pos_m1   = pos - FIW'(1);
  assign rem      = seglen - need[31:0];
  assign heap_ok  = heap_end > heap_start;

  always_comb begin
    stat.cmd      = op_cmd;
    stat.bad_need = (need == 34'd0) || (need[33:32] != 2'd0);
    stat.free_end = fidx >= count;
    stat.fit      = {2'b0, f_rlen} >= need;
    stat.used_end = uidx == USED_N;
    stat.uvalid   = (uidx < USED_N) ? valid[uidx[UAW-1:0]] : 1'b1;
    stat.hit      = stat.uvalid && !stat.used_end && ((u_rstart + HDR32) == addr);
    stat.at_pos   = f_rstart >= s;
    stat.split    = {2'b0, rem} >= BLK34;
    stat.mprev    = (pos != '0) && (({1'b0, pstart} + {1'b0, plen}) == {1'b0, s});
    stat.mnext    = nex && (({1'b0, s} + {1'b0, l}) == {1'b0, nstart});
    stat.full     = !stat.mprev && !stat.mnext && (count >= FREE_N);
    stat.dn_last  = ({1'b0, fidx} + (FIW+1)'(1)) >= {1'b0, count};
    stat.up_last  = fidx == pos;
  end

  // free table port steering
  always_comb begin
    f_we    = 1'b0;
    f_waddr = fidx[FAW-1:0];
    f_wdata = f_rdata;
    f_raddr = fidx[FAW-1:0];
    case (cmd.op)
      S_START: begin
        f_we    = (op_cmd == CMD_INIT) && heap_ok;
        f_waddr = '0;
        f_wdata = {heap_end - heap_start, heap_start};
      end
      S_A_UPD: begin
        f_we    = stat.split;
        f_waddr = fi;
        f_wdata = {rem, base + need[31:0]};
      end
      S_DN_RD:  f_raddr = f_inc[FAW-1:0];
      S_DN_WR:  f_we = 1'b1;
      S_F_DEC: begin
        f_we = !stat.full && (stat.mprev || stat.mnext);
        if (stat.mprev) begin
          f_waddr = pos_m1[FAW-1:0];
          f_wdata = {plen + l + (stat.mnext ? nlen : 32'd0), pstart};
        end else begin
          f_waddr = pos[FAW-1:0];
          f_wdata = {nlen + l, s};
        end
      end
      S_UP_RD: begin
        f_raddr = f_dec[FAW-1:0];
        f_we    = stat.up_last;
        f_waddr = pos[FAW-1:0];
        f_wdata = {l, s};
      end
      S_UP_WR:  f_we = 1'b1;
      default: ;
    endcase
  end

  assign u_we = (cmd.op == S_A_UPD);

  ffa_ram #(.WIDTH(64), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  ffa_ram #(.WIDTH(64), .DEPTH(USED_ENTRIES)) u_used_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (uidx[UAW-1:0]),
    .wdata ({need[31:0], base}),
    .raddr (uidx[UAW-1:0]),
    .rdata (u_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= HEAP_START_RST;
      heap_end   <= HEAP_END_RST;
      count      <= '0;
      fbc        <= '0;
      valid      <= '0;
      st_r       <= STAT_OK;
    end else begin
      if (cfg_we && cfg_index == REG_HEAP_START) heap_start <= cfg_data;
      if (cfg_we && cfg_index == REG_HEAP_END) heap_end <= cfg_data;
      case (cmd.op)
        S_IDLE: begin
          if (cmd.load) begin
            op_cmd <= in_cmd;
            addr   <= in_address;
            need   <= ((({2'b0, in_req_size}) + BLK34 - 34'd1) / BLK34) * BLK34 + HDR34;
          end
        end
        S_START: begin
          st_r  <= (op_cmd == CMD_ALLOC && stat.bad_need) ? STAT_OOM : STAT_OK;
          res_r <= '0;
          fidx  <= '0;
          uidx  <= '0;
          if (op_cmd == CMD_INIT) begin
            valid <= '0;
            count <= heap_ok ? FIW'(1) : '0;
            fbc   <= heap_ok ? heap_end - heap_start : 32'd0;
          end
        end
        S_A_RD:  if (stat.free_end) st_r <= STAT_OOM;
        S_A_CMP: begin
          if (stat.fit) begin
            fi     <= fidx[FAW-1:0];
            base   <= f_rstart;
            seglen <= f_rlen;
          end else begin
            fidx <= f_inc;
          end
        end
        S_U_SCAN: begin
          if (stat.used_end) st_r <= STAT_FULL;
          else if (stat.uvalid) uidx <= uidx + UIW'(1);
        end
        S_A_UPD: begin
          valid[uidx[UAW-1:0]] <= 1'b1;
          fbc   <= fbc - need[31:0];
          res_r <= base + HDR32;
          fidx  <= FIW'(fi);
        end
        S_DN_RD: if (stat.dn_last) count <= count - FIW'(1);
        S_DN_WR: fidx <= f_inc;
        S_F_RD:  if (stat.used_end) st_r <= STAT_NOTALLOC;
        S_F_CMP: begin
          if (stat.hit) begin
            s    <= u_rdata[31:0];
            l    <= u_rdata[63:32];
            j    <= uidx[UAW-1:0];
            fidx <= '0;
          end else begin
            uidx <= uidx + UIW'(1);
          end
        end
        S_P_RD: begin
          if (stat.free_end) begin
            pos <= fidx;
            nex <= 1'b0;
          end
        end
        S_P_CMP: begin
          if (stat.at_pos) begin
            pos    <= fidx;
            nex    <= 1'b1;
            nstart <= f_rstart;
            nlen   <= f_rlen;
          end else begin
            pstart <= f_rstart;
            plen   <= f_rlen;
            fidx   <= f_inc;
          end
        end
        S_F_DEC: begin
          if (stat.full) begin
            st_r <= STAT_FULL;
          end else begin
            valid[j] <= 1'b0;
            fbc      <= fbc + l;
            if (stat.mprev && stat.mnext) fidx <= pos;
            else if (!stat.mprev && !stat.mnext) fidx <= count;
          end
        end
        S_UP_RD: if (stat.up_last) count <= count + FIW'(1);
        S_UP_WR: fidx <= f_dec;
        S_L_START: begin
          fidx <= '0;
          best <= '0;
        end
        S_L_CMP: begin
          if (f_rlen > best) best <= f_rlen;
          fidx <= f_inc;
        end
        default: ;
      endcase
    end
  end

  assign status             = st_r;
  assign result_address     = res_r;
  assign free_bytes         = fbc;
  assign largest_free_bytes = best;

endmodule

[hw/rtl/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with address-ordered free list and coalescing.
// ----------------------------------------------------------------------------
//  channel   | direction | transfer carries
//  s_axis    | in        | cmd, req_size, address
//  m_axis    | out       | status, result_address, free_bytes, largest_free_bytes
//  cfg       | in        | register index, 32-bit value
//
// One item at a time. Table scans read each entry through the registered read
// port of the free or used RAM, then compare or write it; the used-slot probe
// reads valid bits. Allocate seeks the first fit, probes used slots, shifts
// entries down if nothing is split; free seeks the used entry and the insert
// position, then shifts if needed; each command ends with a largest-segment
// scan. Reset is synchronous. The result holds on m_axis until taken; s_axis stalls until then.
module first_fit_heap_allocator_top #(
  parameter int BLOCK_BYTES  = ffa_pkg::BLOCK_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int FREE_ENTRIES = ffa_pkg::FREE_ENTRIES_DEF,
  parameter int USED_ENTRIES = ffa_pkg::USED_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // cmd[1:0], req_size[33:2], address[65:34]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // status[1:0], result_address[33:2],
                                       // free_bytes[65:34], largest_free_bytes[97:66]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ffa_pkg::*;

  ffa_cmd_t    cmd;
  ffa_stat_t   stat;
  logic [1:0]  status;
  logic [31:0] result_address;
  logic [31:0] free_bytes;
  logic [31:0] largest_free_bytes;

  assign cfg_ready = 1'b1;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffa_dp #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .FREE_ENTRIES (FREE_ENTRIES),
    .USED_ENTRIES (USED_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cmd             (s_axis_tdata[1:0]),
    .in_req_size        (s_axis_tdata[33:2]),
    .in_address         (s_axis_tdata[65:34]),
    .cmd                (cmd),
    .stat               (stat),
    .status             (status),
    .result_address     (result_address),
    .free_bytes         (free_bytes),
    .largest_free_bytes (largest_free_bytes)
  );

  assign m_axis_tdata = {6'd0, largest_free_bytes, free_bytes, result_address, status};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status != STAT_OK) |-> (result_address == 32'd0))
    else $error("failed command returned a nonzero address");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result repeated after transfer");

endmodule
